// ===== design/spd_pkg.sv =====
// ----------------------------------------------------------------------------
// spd_pkg
// Shared widths, codes and structs of the dense-graph shortest path engine.
// ----------------------------------------------------------------------------
package spd_pkg;

  // default graph size
  localparam int NodesDefault = 16;

  // longest path that is emitted, counted in nodes
  localparam int MaxOut = 16;

  // field widths
  localparam int NodeW   = 4;
  localparam int WeightW = 10;
  localparam int DistW   = 15;
  localparam int StatusW = 2;

  // distance that stands for "no path"
  localparam logic [DistW-1:0] InfDist = 15'd32767;

  // input command codes
  localparam logic CmdWrite = 1'b0;
  localparam logic CmdQuery = 1'b1;

  // result status codes
  typedef enum logic [StatusW-1:0] {
    StatusPath    = 2'd0,
    StatusSame    = 2'd1,
    StatusUnreach = 2'd2
  } status_e;

  // one node entry on its way into the relax/select stage
  typedef struct packed {
    logic               vld;
    logic               init;
    logic               done;
    logic               is_src;
    logic [WeightW-1:0] w;
    logic [DistW-1:0]   cur_dist;
    logic [DistW-1:0]   base;
  } relax_req_t;

  // write-back decision of the relax/select stage
  typedef struct packed {
    logic             wr;
    logic             has_edge;
    logic [DistW-1:0] wr_dist;
  } relax_rsp_t;

endpackage

// ===== design/spd_if.sv =====
// ----------------------------------------------------------------------------
// spd_in_if / spd_out_if
// Valid/ready channels of the shortest path engine: command beats in,
// path node beats out.
// ----------------------------------------------------------------------------
interface spd_in_if import spd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               command;
  logic [NodeW-1:0]   from_node;
  logic [NodeW-1:0]   to_node;
  logic [WeightW-1:0] weight;

  modport source (output valid, command, from_node, to_node, weight, input ready);
  modport sink   (input valid, command, from_node, to_node, weight, output ready);
endinterface

interface spd_out_if import spd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [NodeW-1:0]   node;
  logic [DistW-1:0]   total_distance;
  logic [StatusW-1:0] status;
  logic               last;

  modport source (output valid, node, total_distance, status, last, input ready);
  modport sink   (input valid, node, total_distance, status, last, output ready);
endinterface

// ===== design/spd_relax.sv =====
// ----------------------------------------------------------------------------
// spd_relax
// Second stage of a node sweep: relaxes one node against the current pick
// (or loads its first distance) and tracks the minimum for the next pick.
// ----------------------------------------------------------------------------
module spd_relax import spd_pkg::*; #(
  parameter int  Nodes = NodesDefault,
  localparam int NW    = $clog2(Nodes)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  relax_req_t       req_i,
  input  logic [NW-1:0]    idx_i,
  input  logic             sel_clr_i,
  output relax_rsp_t       rsp_o,
  output logic [NW-1:0]    sel_best_o,
  output logic [DistW-1:0] sel_low_o
);

  logic [DistW:0]   sum;
  logic             has_edge;
  logic             upd;
  logic [DistW-1:0] new_dist;
  logic             cand;
  logic [NW-1:0]    best_q;
  logic [DistW-1:0] low_q;

  // path length through the pick, one bit wider than a distance
  assign sum      = (DistW+1)'(req_i.base) + (DistW+1)'(req_i.w);
  assign has_edge = (req_i.w != '0);
  assign upd      = has_edge && !req_i.done && (sum < {1'b0, req_i.cur_dist});

  // distance after this stage
  always_comb begin
    if (req_i.init) begin
      if (req_i.is_src) begin
        new_dist = '0;
      end else if (has_edge) begin
        new_dist = DistW'(req_i.w);
      end else begin
        new_dist = InfDist;
      end
    end else begin
      new_dist = upd ? sum[DistW-1:0] : req_i.cur_dist;
    end
  end

  assign rsp_o.wr       = req_i.vld && (req_i.init || upd);
  assign rsp_o.has_edge = has_edge;
  assign rsp_o.wr_dist  = new_dist;

  // minimum search, ties go to the higher index
  assign cand       = req_i.vld && !req_i.done && (new_dist <= low_q);
  assign sel_best_o = cand ? idx_i : best_q;
  assign sel_low_o  = cand ? new_dist : low_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q <= '0;
      low_q  <= InfDist;
    end else if (sel_clr_i) begin
      best_q <= '0;
      low_q  <= InfDist;
    end else begin
      best_q <= sel_best_o;
      low_q  <= sel_low_o;
    end
  end

endmodule

// ===== design/shortest_path_dense_graph.sv =====
// ----------------------------------------------------------------------------
// shortest_path_dense_graph
// Dijkstra search over a NODES x NODES edge weight matrix held in RAM,
// with the path emitted source first, one node per beat.
//
//   channel | dir | beat contents
//   --------+-----+---------------------------------------------------------
//   in_i    | in  | command, from_node, to_node, weight (write or query)
//   out_o   | out | node, total_distance, status, last
//
// A query runs a series of node sweeps (one node-memory and one edge-memory
// read per cycle, a drain state after each sweep), then a predecessor walk
// and the emission of the path, one node per beat.
// After reset the edge memory is cleared, one entry per cycle, while
// in_i.ready stays low.
// A stalled out_o holds the engine; a new beat is taken as soon as the final
// result sits in the output register.
// ----------------------------------------------------------------------------
module shortest_path_dense_graph import spd_pkg::*; #(
  parameter int NODES = NodesDefault
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  spd_in_if.sink   in_i,
  spd_out_if.source out_o
);

  localparam int NW    = $clog2(NODES);
  localparam int EDGES = NODES * NODES;
  localparam int EW    = $clog2(EDGES);
  localparam int LW    = $clog2(NODES + 1);
  localparam int SW    = $clog2(MaxOut);
  localparam int EntW  = DistW + NW;

  typedef enum logic [9:0] {
    StClear = 10'b0000000001,
    StIdle  = 10'b0000000010,
    StSweep = 10'b0000000100,
    StDrain = 10'b0000001000,
    StFetch = 10'b0000010000,
    StTotal = 10'b0000100000,
    StWalk  = 10'b0001000000,
    StPop   = 10'b0010000000,
    StEmit  = 10'b0100000000,
    StStat  = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  // control registers
  logic [EW-1:0]    clr_q;
  logic [NW-1:0]    src_q;
  logic [NodeW-1:0] dst_q;
  logic [NW-1:0]    idx_q;
  logic [NW-1:0]    rnd_q;
  logic             init_q;
  logic [NW-1:0]    best_q;
  logic [DistW-1:0] best_dist_q;
  logic [NODES-1:0] done_q;
  logic             p_vld_q;
  logic [NW-1:0]    p_idx_q;
  logic             p_init_q;
  logic [DistW-1:0] total_q;
  status_e          stat_q;
  logic [NW-1:0]    cur_q;
  logic [LW-1:0]    len_q;
  logic [SW-1:0]    pop_q;

  // output register
  logic             out_valid_q;
  logic [NodeW-1:0] out_node_q;
  logic [DistW-1:0] out_dist_q;
  status_e          out_status_q;
  logic             out_last_q;

  // memories
  logic [WeightW-1:0] edge_mem [EDGES];
  logic [WeightW-1:0] edge_rd_q;
  logic [EntW-1:0]    node_mem [NODES];
  logic [EntW-1:0]    node_rd_q;
  logic [NodeW-1:0]   stack_mem [MaxOut];
  logic [NodeW-1:0]   stack_rd_q;

  logic               in_acc;
  logic               in_range;
  logic               is_query;
  logic [NW-1:0]      dst_idx;
  logic               last_rnd;
  logic               walk_end;
  logic               out_free;
  logic               out_load;

  logic               e_we;
  logic [EW-1:0]      e_waddr;
  logic [WeightW-1:0] e_wdata;
  logic               e_re;
  logic [EW-1:0]      e_raddr;

  logic               n_we;
  logic [NW-1:0]      n_waddr;
  logic [EntW-1:0]    n_wdata;
  logic               n_re;
  logic [NW-1:0]      n_raddr;
  logic [DistW-1:0]   rd_dist;
  logic [NW-1:0]      rd_pred;
  logic [NW-1:0]      wr_pred;

  logic               s_we;
  logic [SW-1:0]      s_waddr;
  logic [NodeW-1:0]   s_wdata;

  relax_req_t         rlx_req;
  relax_rsp_t         rlx_rsp;
  logic               sel_clr;
  logic [NW-1:0]      sel_best;
  logic [DistW-1:0]   sel_low;

  // input handshake and decode
  assign in_i.ready = (state_q == StIdle);
  assign in_acc     = in_i.valid && in_i.ready;
  assign in_range   = (32'(in_i.from_node) < NODES) && (32'(in_i.to_node) < NODES);
  assign is_query   = (in_i.command == CmdQuery);
  assign dst_idx    = NW'(dst_q);
  assign last_rnd   = (rnd_q == NW'(NODES - 1));
  assign walk_end   = (cur_q == src_q) || (32'(len_q) + 32'd1 >= NODES);
  assign out_free   = !out_valid_q || out_o.ready;
  assign out_load   = out_free && ((state_q == StEmit) || (state_q == StStat));

  assign rd_dist = node_rd_q[EntW-1 -: DistW];
  assign rd_pred = node_rd_q[NW-1:0];

  // edge memory ports
  assign e_we    = (state_q == StClear) || (in_acc && !is_query && in_range);
  assign e_waddr = (state_q == StClear) ? clr_q
                 : EW'(32'(in_i.from_node) * NODES + 32'(in_i.to_node));
  assign e_wdata = (state_q == StClear) ? '0 : in_i.weight;
  assign e_re    = (state_q == StSweep);
  assign e_raddr = EW'(32'(best_q) * NODES + 32'(idx_q));

  always_ff @(posedge clk_i) begin
    if (e_we) begin
      edge_mem[e_waddr] <= e_wdata;
    end
    if (e_re) begin
      edge_rd_q <= edge_mem[e_raddr];
    end
  end

  // relax/select stage
  assign rlx_req.vld      = p_vld_q;
  assign rlx_req.init     = p_init_q;
  assign rlx_req.done     = done_q[p_idx_q];
  assign rlx_req.is_src   = (p_idx_q == src_q);
  assign rlx_req.w        = edge_rd_q;
  assign rlx_req.cur_dist = rd_dist;
  assign rlx_req.base     = best_dist_q;
  assign sel_clr          = (in_acc && is_query) || (state_q == StDrain);

  spd_relax #(
    .Nodes (NODES)
  ) u_relax (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (rlx_req),
    .idx_i      (p_idx_q),
    .sel_clr_i  (sel_clr),
    .rsp_o      (rlx_rsp),
    .sel_best_o (sel_best),
    .sel_low_o  (sel_low)
  );

  // node memory ports: sweep reads by index, walk reads by predecessor
  assign wr_pred = p_init_q ? (rlx_rsp.has_edge ? src_q : '0) : best_q;
  assign n_we    = rlx_rsp.wr;
  assign n_waddr = p_idx_q;
  assign n_wdata = {rlx_rsp.wr_dist, wr_pred};
  assign n_re    = (state_q == StSweep) || (state_q == StFetch) ||
                   (state_q == StTotal) || (state_q == StWalk);

  always_comb begin
    case (state_q)
      StSweep: n_raddr = idx_q;
      StFetch: n_raddr = dst_idx;
      default: n_raddr = rd_pred;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (n_we) begin
      node_mem[n_waddr] <= n_wdata;
    end
    if (n_re) begin
      node_rd_q <= node_mem[n_raddr];
    end
  end

  // path stack, destination at entry zero
  assign s_we    = ((state_q == StTotal) && (rd_dist < InfDist)) ||
                   ((state_q == StWalk) && (32'(len_q) < MaxOut));
  assign s_waddr = (state_q == StTotal) ? '0 : SW'(len_q);
  assign s_wdata = (state_q == StTotal) ? dst_q : NodeW'(cur_q);

  always_ff @(posedge clk_i) begin
    if (s_we) begin
      stack_mem[s_waddr] <= s_wdata;
    end
    if (state_q == StPop) begin
      stack_rd_q <= stack_mem[pop_q];
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StClear: if (clr_q == EW'(EDGES - 1)) state_d = StIdle;
      StIdle: begin
        if (in_acc && is_query) begin
          if (!in_range || (in_i.from_node == in_i.to_node)) begin
            state_d = StStat;
          end else begin
            state_d = StSweep;
          end
        end
      end
      StSweep: if (idx_q == NW'(NODES - 1)) state_d = StDrain;
      StDrain: state_d = last_rnd ? StFetch : StSweep;
      StFetch: state_d = StTotal;
      StTotal: state_d = (rd_dist >= InfDist) ? StStat : StWalk;
      StWalk:  if (walk_end) state_d = StPop;
      StPop:   state_d = StEmit;
      StEmit: begin
        if (out_free) state_d = (pop_q == '0) ? StIdle : StPop;
      end
      StStat:  if (out_free) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      clr_q       <= '0;
      src_q       <= '0;
      dst_q       <= '0;
      idx_q       <= '0;
      rnd_q       <= '0;
      init_q      <= 1'b0;
      best_q      <= '0;
      best_dist_q <= '0;
      done_q      <= '0;
      p_vld_q     <= 1'b0;
      p_idx_q     <= '0;
      p_init_q    <= 1'b0;
      total_q     <= '0;
      stat_q      <= StatusPath;
      cur_q       <= '0;
      len_q       <= '0;
      pop_q       <= '0;
    end else begin
      state_q  <= state_d;
      p_vld_q  <= (state_q == StSweep);
      p_idx_q  <= idx_q;
      p_init_q <= init_q;

      unique case (state_q) inside
        StClear: clr_q <= clr_q + EW'(1);
        StIdle: begin
          if (in_acc && is_query) begin
            dst_q <= in_i.to_node;
            if (!in_range) begin
              stat_q  <= StatusUnreach;
              total_q <= InfDist;
            end else if (in_i.from_node == in_i.to_node) begin
              stat_q  <= StatusSame;
              total_q <= '0;
            end else begin
              src_q          <= NW'(in_i.from_node);
              best_q         <= NW'(in_i.from_node);
              // only the source starts out visited
              done_q         <= {{(NODES-1){1'b0}}, 1'b1} << NW'(in_i.from_node);
              idx_q          <= '0;
              rnd_q          <= '0;
              init_q         <= 1'b1;
            end
          end
        end
        StSweep: idx_q <= idx_q + NW'(1);
        StDrain: begin
          // take the pick for the next relax sweep
          if (!last_rnd) begin
            rnd_q            <= rnd_q + NW'(1);
            best_q           <= sel_best;
            best_dist_q      <= sel_low;
            done_q[sel_best] <= 1'b1;
            init_q           <= 1'b0;
            idx_q            <= '0;
          end
        end
        StTotal: begin
          if (rd_dist >= InfDist) begin
            stat_q  <= StatusUnreach;
            total_q <= InfDist;
          end else begin
            stat_q  <= StatusPath;
            total_q <= rd_dist;
            len_q   <= LW'(1);
            cur_q   <= rd_pred;
          end
        end
        StWalk: begin
          len_q <= len_q + LW'(1);
          if (walk_end) begin
            pop_q <= (32'(len_q) >= MaxOut) ? SW'(MaxOut - 1) : SW'(len_q);
          end else begin
            cur_q <= rd_pred;
          end
        end
        StEmit: begin
          if (out_free && (pop_q != '0)) pop_q <= pop_q - SW'(1);
        end
        StFetch, StPop, StStat: ;
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      out_node_q   <= '0;
      out_dist_q   <= '0;
      out_status_q <= StatusPath;
      out_last_q   <= 1'b0;
    end else if (out_load) begin
      out_valid_q  <= 1'b1;
      out_dist_q   <= total_q;
      out_status_q <= stat_q;
      if (state_q == StEmit) begin
        out_node_q <= stack_rd_q;
        out_last_q <= (pop_q == '0);
      end else begin
        out_node_q <= dst_q;
        out_last_q <= 1'b1;
      end
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.node           = out_node_q;
  assign out_o.total_distance = out_dist_q;
  assign out_o.status         = out_status_q;
  assign out_o.last           = out_last_q;

`ifndef SYNTH
  // sweep reads never meet the relax write-back on the same entry
  a_node_rw_apart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (n_we && n_re) |-> (n_waddr != n_raddr))
    else $error("node memory read and write hit the same entry");

  // the source stays visited through every sweep
  a_src_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StSweep) |-> done_q[src_q])
    else $error("source node not marked visited during sweep");

  // a pick taken for the next round is always an unvisited node
  a_pick_fresh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == StDrain) && !last_rnd) |-> !done_q[sel_best])
    else $error("selected node was already visited");

  // status beats are always the final beat of a query
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_status_q != StatusPath)) |-> out_last_q)
    else $error("status result not flagged last");
`endif

endmodule

// ===== tb/spd_route_checker.sv =====
// ----------------------------------------------------------------------------
// spd_route_checker
// Watches the command and route channels of the shortest path engine. It
// keeps its own copy of the edge matrix, runs the search on every query beat
// and compares each route beat, field by field, with the oldest one owed.
// ----------------------------------------------------------------------------
module spd_route_checker import spd_pkg::*; #(
  parameter int NODES = NodesDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  spd_in_if    in_mon,
  spd_out_if   out_mon,
  output int   fail_count,
  output int   beats_owed
);

  // one route beat as the engine should send it
  typedef struct packed {
    logic [NodeW-1:0] node;
    logic [DistW-1:0] total;
    status_e          status;
    logic             last;
  } route_beat_t;

  // mirrored graph and search scratch state
  logic [WeightW-1:0] weight_mem [NODES][NODES];
  logic [DistW-1:0]   dist_tab   [NODES];
  logic               visited    [NODES];
  logic [NodeW-1:0]   pred_tab   [NODES];

  route_beat_t route_q [$];
  route_beat_t due;

  // append one owed beat at the tail
  function automatic void owe_beat(input route_beat_t b);
    route_q = {route_q, b};
  endfunction

  // Dijkstra from src; queues the beats owed for the route to dst
  function automatic void plan_route(input int src, input int dst);
    int          best;
    int          low;
    int          nd;
    int          cur;
    int          first;
    int          trail [$];
    route_beat_t b;
    if (src == dst) begin
      b = '{node: NodeW'(dst), total: '0, status: StatusSame, last: 1'b1};
      owe_beat(b);
      return;
    end
    // seed from the source row
    for (int i = 0; i < NODES; i++) begin
      if (weight_mem[src][i] != '0) begin
        dist_tab[i] = DistW'(weight_mem[src][i]);
        pred_tab[i] = NodeW'(src);
      end else begin
        dist_tab[i] = InfDist;
        pred_tab[i] = '0;
      end
      visited[i] = 1'b0;
    end
    dist_tab[src] = '0;
    visited[src]  = 1'b1;
    // selection rounds: ties go to the highest index
    for (int r = 1; r < NODES; r++) begin
      best = 0;
      low  = int'(InfDist);
      for (int i = 0; i < NODES; i++) begin
        if (!visited[i] && int'(dist_tab[i]) <= low) begin
          low  = int'(dist_tab[i]);
          best = i;
        end
      end
      visited[best] = 1'b1;
      for (int i = 0; i < NODES; i++) begin
        if (i == best || i == src) continue;
        if (weight_mem[best][i] != '0 && !visited[i]) begin
          nd = int'(dist_tab[best]) + int'(weight_mem[best][i]);
          if (nd < int'(dist_tab[i])) begin
            dist_tab[i] = DistW'(nd);
            pred_tab[i] = NodeW'(best);
          end
        end
      end
    end
    if (dist_tab[dst] >= InfDist) begin
      b = '{node: NodeW'(dst), total: InfDist, status: StatusUnreach, last: 1'b1};
      owe_beat(b);
      return;
    end
    // walk predecessors back, source ends up at the front
    cur = dst;
    trail.push_front(cur);
    while (cur != src && trail.size() < NODES) begin
      cur = int'(pred_tab[cur % NODES]);
      trail.push_front(cur);
    end
    first = (trail.size() > MaxOut) ? trail.size() - MaxOut : 0;
    for (int k = first; k < trail.size(); k++) begin
      b.node   = NodeW'(trail[k]);
      b.total  = dist_tab[dst];
      b.status = StatusPath;
      b.last   = (k == trail.size() - 1);
      owe_beat(b);
    end
  endfunction

  task automatic flag_field(input string field, input int want, input int got);
    fail_count++;
    $error("%s: expected %0d, got %0d", field, want, got);
  endtask

  // route beats are checked before the command beat of the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (weight_mem[r, c]) weight_mem[r][c] = '0;
      route_q.delete();
      fail_count = 0;
      beats_owed = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (route_q.size() == 0) begin
          fail_count++;
          $error("route beat with nothing owed: node %0d, status %0d",
                 out_mon.node, out_mon.status);
        end else begin
          due = route_q.pop_front();
          if (out_mon.node !== due.node)
            flag_field("node", due.node, out_mon.node);
          if (out_mon.total_distance !== due.total)
            flag_field("total_distance", due.total, out_mon.total_distance);
          if (out_mon.status !== due.status)
            flag_field("status", due.status, out_mon.status);
          if (out_mon.last !== due.last)
            flag_field("last", due.last, out_mon.last);
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.command == CmdQuery)
          plan_route(int'(in_mon.from_node), int'(in_mon.to_node));
        else
          weight_mem[in_mon.from_node][in_mon.to_node] = in_mon.weight;
      end
      beats_owed = route_q.size();
    end
  end

endmodule

// ===== tb/shortest_path_dense_graph_tb.sv =====
// ----------------------------------------------------------------------------
// shortest_path_dense_graph_tb
// Drives edge writes and route queries into the shortest path engine with
// bursty command traffic and a stalling route receiver; a checker beside
// the engine predicts every route beat. Directed graphs first (empty graph,
// same node, a full-length chain, a shortcut added and removed), then
// random graphs and queries.
// ----------------------------------------------------------------------------
module shortest_path_dense_graph_tb;
  import spd_pkg::*;

  localparam int RandomItems = 95;
  localparam int IdleLimit   = 4000;
  localparam int DrainCycles = 20;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   beats_owed;
  int   burst_left;
  int   ready_hold;
  int   idle_cycles;

  spd_in_if  cmd_ch ();
  spd_out_if route_ch ();

  shortest_path_dense_graph #(
    .NODES(NodesDefault)
  ) u_top (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (cmd_ch),
    .out_o (route_ch)
  );

  spd_route_checker #(
    .NODES(NodesDefault)
  ) u_check (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .in_mon    (cmd_ch),
    .out_mon   (route_ch),
    .fail_count(fail_count),
    .beats_owed(beats_owed)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // one command beat; bursts keep valid high, gaps drop it
  task automatic send_beat(input logic cmd, input logic [NodeW-1:0] src,
                           input logic [NodeW-1:0] dst, input logic [WeightW-1:0] w);
    @(negedge clk);
    cmd_ch.valid     = 1'b1;
    cmd_ch.command   = cmd;
    cmd_ch.from_node = src;
    cmd_ch.to_node   = dst;
    cmd_ch.weight    = w;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      @(negedge clk);
      cmd_ch.valid = 1'b0;
      repeat ($urandom_range(0, 11)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                               : $urandom_range(0, 5);
    end
  endtask

  task automatic write_edge(input int src, input int dst, input int w);
    send_beat(CmdWrite, NodeW'(src), NodeW'(dst), WeightW'(w));
  endtask

  // weight field is don't-care on queries, so it carries noise
  task automatic ask_route(input int src, input int dst);
    send_beat(CmdQuery, NodeW'(src), NodeW'(dst), WeightW'($urandom_range(0, 1023)));
  endtask

  // small weights make ties, zero deletes an edge
  function automatic int pick_weight();
    case ($urandom_range(0, 5)) inside
      0:       return 0;
      1, 2:    return $urandom_range(1, 8);
      3:       return 1023;
      default: return $urandom_range(0, 1023);
    endcase
  endfunction

  // route receiver: short stalls, occasional long ones, long open stretches
  always @(negedge clk) begin
    if (ready_hold == 0) begin
      if (route_ch.ready) begin
        route_ch.ready = 1'b0;
        ready_hold = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 20)
                                                 : $urandom_range(1, 3);
      end else begin
        route_ch.ready = 1'b1;
        ready_hold = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 90)
                                                 : $urandom_range(1, 6);
      end
    end else begin
      ready_hold--;
    end
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((cmd_ch.valid && cmd_ch.ready) || (route_ch.valid && route_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    int sent;
    int head;
    int cur;
    int nxt;
    int hops;
    int src;
    cmd_ch.valid     = 1'b0;
    cmd_ch.command   = CmdWrite;
    cmd_ch.from_node = '0;
    cmd_ch.to_node   = '0;
    cmd_ch.weight    = '0;
    route_ch.ready   = 1'b0;
    ready_hold       = 0;
    idle_cycles      = 0;
    burst_left       = 0;
    sent             = 0;
    rst_n            = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // empty graph: unreachable both ways, and source equal to destination
    ask_route(3, 7);
    ask_route(5, 5);
    ask_route(0, 15);
    ask_route(15, 0);
    // chain through every node, weights swinging between the extremes
    for (int n = 0; n < 15; n++) write_edge(n, n + 1, (n % 2 == 0) ? 1023 : 1);
    ask_route(0, 15);
    ask_route(15, 0);
    // shortcut added, then deleted with a zero weight
    write_edge(0, 15, 512);
    ask_route(0, 15);
    write_edge(0, 15, 0);
    ask_route(0, 15);

    // random graphs: mostly single edges and queries, some short chains
    while (sent < RandomItems) begin
      case ($urandom_range(0, 9)) inside
        0: begin
          head = $urandom_range(0, 15);
          cur  = head;
          hops = $urandom_range(3, 8);
          for (int k = 0; k < hops; k++) begin
            nxt = $urandom_range(0, 15);
            write_edge(cur, nxt, $urandom_range(1, 40));
            cur = nxt;
          end
          ask_route(head, cur);
          sent += hops + 1;
        end
        1, 2, 3, 4, 5: begin
          write_edge($urandom_range(0, 15), $urandom_range(0, 15), pick_weight());
          sent++;
        end
        default: begin
          src = $urandom_range(0, 15);
          ask_route(src, ($urandom_range(0, 7) == 0) ? src : $urandom_range(0, 15));
          sent++;
        end
      endcase
    end

    // let the valid drop, wait for every owed beat, then a short drain
    @(negedge clk);
    cmd_ch.valid = 1'b0;
    while (beats_owed != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
